// File: src/fra_pkg.sv
// Shared types, constants and status codes of the frame fragment reassembler.
package fra_pkg;

  localparam int unsigned MAX_FRAGMENTS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam logic [31:0] MAX_FRAME_RESET   = 32'd4194304;
  localparam logic [16:0] HEADER_BYTES      = 17'd40;
  localparam logic [7:0]  MAGIC_A           = 8'h50;
  localparam logic [7:0]  MAGIC_B           = 8'h58;

  localparam int unsigned IN_DATA_W   = 184;
  localparam int unsigned OUT_DATA_W  = 112;
  localparam int unsigned OUT_USER_W  = 6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_PAST_END  = 3'd5,
    ST_TOO_MANY  = 3'd6
  } fra_status_t;

  typedef struct packed {
    fra_status_t status;
    logic [31:0] frame_number;
    logic [31:0] frame_total_bytes;
    logic [31:0] fragment_offset;
    logic [15:0] fragment_length;
    logic [15:0] fragment_index;
    logic [15:0] fragment_total;
  } fra_item_t;

  typedef struct packed {
    fra_status_t status;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic        frame_started;
    logic        partial_dropped;
    logic        duplicate_fragment;
    logic        frame_complete;
    logic [31:0] complete_size;
    logic [31:0] drop_count;
  } fra_result_t;

endpackage

// File: src/frame_fragment_reassembler.sv
// Top level of the frame fragment reassembler.
//
// The block takes one parsed fragment header per beat and returns one result beat for it.
// It accepts a beat every clock cycle while results drain. An accepted header is written
// into the queue, and when it is popped its result is written into the output register,
// which presents the result beat. A front part checks the header combinationally and
// places it in a two-entry queue, and a back part performs the bitmap read, update and
// completion test of one fragment per cycle while the output register can take a result.
// While m_tready stays low the output register and both queue entries fill, and s_tready
// drops once the queue holds two headers. The bitmap is cleared in the same cycle a new
// frame starts, so no clearing pass is needed after reset. The user must write
// max_frame_bytes only while the block is idle; the block itself does not enforce this.
module frame_fragment_reassembler #(
  parameter int unsigned MAX_FRAGMENTS = fra_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [31:0]                    cfg_wr_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // captured_length, magic_first, magic_second, frame_number, frame_total_bytes,
  // fragment_offset, fragment_length, fragment_index, fragment_total, zero fill
  input  logic [fra_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // write_offset, write_length, complete_size, drop_count
  output logic [fra_pkg::OUT_DATA_W-1:0] m_tdata,
  // status, frame_started, partial_dropped, duplicate_fragment
  output logic [fra_pkg::OUT_USER_W-1:0] m_tuser,
  // frame_complete
  output logic                           m_tlast
);
  import fra_pkg::*;

  logic        push;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  fra_item_t   push_item;
  fra_item_t   head_item;
  fra_result_t out_result;

  fra_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .queue_full  (queue_full),
    .push        (push),
    .item        (push_item)
  );

  fra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  fra_back #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tdata = {out_result.drop_count, out_result.complete_size,
                    out_result.write_length, out_result.write_offset};
  assign m_tuser = {out_result.duplicate_fragment, out_result.partial_dropped,
                    out_result.frame_started, out_result.status};
  assign m_tlast = out_result.frame_complete;

  a_complete_is_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_result.status == ST_OK)
    else $error("Completion reported on a rejected fragment.");

  a_drop_needs_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_result.partial_dropped |-> out_result.frame_started)
    else $error("Partial frame dropped without a new frame starting.");

  a_dup_not_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_result.duplicate_fragment |-> !out_result.frame_started)
    else $error("Duplicate reported on the first fragment of a frame.");

  a_pop_has_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (!m_tvalid || m_tready))
    else $error("Queue popped while the result register was occupied.");

endmodule

// File: src/fra_front.sv
// Front part: takes header beats, applies the header checks and classifies them.
module fra_front #(
  parameter int unsigned MAX_FRAGMENTS = fra_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fra_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            queue_full,
  output logic                            push,
  output fra_pkg::fra_item_t              item
);
  import fra_pkg::*;

  localparam logic [16:0] MAX_W = 17'(MAX_FRAGMENTS);

  logic [31:0] max_frame_bytes;
  logic [16:0] captured_length;
  logic [7:0]  magic_first;
  logic [7:0]  magic_second;
  logic [31:0] frame_number;
  logic [31:0] frame_total_bytes;
  logic [31:0] fragment_offset;
  logic [15:0] fragment_length;
  logic [15:0] fragment_index;
  logic [15:0] fragment_total;
  logic        bad_size;
  logic        trunc;
  logic        past_end;
  fra_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_frame_bytes <= cfg_wr_data;
    end
  end

  assign captured_length   = s_tdata[16:0];
  assign magic_first       = s_tdata[24:17];
  assign magic_second      = s_tdata[32:25];
  assign frame_number      = s_tdata[64:33];
  assign frame_total_bytes = s_tdata[96:65];
  assign fragment_offset   = s_tdata[128:97];
  assign fragment_length   = s_tdata[144:129];
  assign fragment_index    = s_tdata[160:145];
  assign fragment_total    = s_tdata[176:161];

  assign bad_size = (frame_total_bytes == 32'd0) || (frame_total_bytes > max_frame_bytes) ||
                    (fragment_total == 16'd0) || (fragment_index >= fragment_total);
  assign trunc    = (HEADER_BYTES + {1'b0, fragment_length}) > captured_length;
  assign past_end = ({1'b0, fragment_offset} + {17'd0, fragment_length}) >
                    {1'b0, frame_total_bytes};

  always_comb begin
    priority if (captured_length < HEADER_BYTES) begin
      status = ST_SHORT;
    end else if (magic_first != MAGIC_A || magic_second != MAGIC_B) begin
      status = ST_MAGIC;
    end else if (bad_size) begin
      status = ST_BAD_SIZE;
    end else if (trunc) begin
      status = ST_TRUNC;
    end else if (past_end) begin
      status = ST_PAST_END;
    end else if ({1'b0, fragment_total} > MAX_W) begin
      status = ST_TOO_MANY;
    end else begin
      status = ST_OK;
    end
  end

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  assign item.status            = status;
  assign item.frame_number      = frame_number;
  assign item.frame_total_bytes = frame_total_bytes;
  assign item.fragment_offset   = fragment_offset;
  assign item.fragment_length   = fragment_length;
  assign item.fragment_index    = fragment_index;
  assign item.fragment_total    = fragment_total;

endmodule

// File: src/fra_queue.sv
// Two-entry queue of classified headers between the front and back parts.
module fra_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fra_pkg::fra_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output fra_pkg::fra_item_t head_item
);
  import fra_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  fra_item_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      unique case ({push, pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/fra_back.sv
// Back part: frame tracking, fragment bitmap, completion and the result register.
module fra_back #(
  parameter int unsigned MAX_FRAGMENTS = fra_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  fra_pkg::fra_item_t  head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output fra_pkg::fra_result_t out_result
);
  import fra_pkg::*;

  localparam int unsigned IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAGMENTS + 1);
  localparam logic [16:0] MAX_W = 17'(MAX_FRAGMENTS);

  logic                     frame_active;
  logic [31:0]              cur_frame_number;
  logic [31:0]              expected_bytes;
  logic [CNT_W-1:0]         expected_fragments;
  logic [CNT_W-1:0]         fragments_seen;
  logic [MAX_FRAGMENTS-1:0] seen_map;
  logic [31:0]              drop_total;

  logic                     frame_active_next;
  logic [31:0]              expected_bytes_next;
  logic [CNT_W-1:0]         expected_fragments_next;
  logic [CNT_W-1:0]         fragments_seen_next;
  logic [MAX_FRAGMENTS-1:0] seen_map_next;
  logic [31:0]              drop_total_next;

  logic                     accepted;
  logic                     new_frame;
  logic                     pdrop;
  logic                     in_range;
  logic [IDX_W-1:0]         idx;
  logic                     seen_bit;
  logic                     dup;
  logic                     done;
  fra_result_t              result;

  assign pop      = head_valid && (!out_valid || out_ready);
  assign accepted = (head_item.status == ST_OK);
  assign new_frame = !frame_active || (head_item.frame_number != cur_frame_number);
  assign pdrop    = new_frame && frame_active && (fragments_seen < expected_fragments);
  assign in_range = ({1'b0, head_item.fragment_index} < MAX_W);
  assign idx      = head_item.fragment_index[IDX_W-1:0];

  always_comb begin
    seen_map_next = new_frame ? '0 : seen_map;
    seen_bit      = in_range && seen_map_next[idx];
    dup           = seen_bit;
    if (in_range) begin
      seen_map_next[idx] = 1'b1;
    end
    expected_bytes_next     = new_frame ? head_item.frame_total_bytes : expected_bytes;
    expected_fragments_next = new_frame ? CNT_W'(head_item.fragment_total)
                                        : expected_fragments;
    fragments_seen_next     = CNT_W'((new_frame ? '0 : fragments_seen) +
                                     {{(CNT_W-1){1'b0}}, (in_range && !seen_bit)});
    done                    = (fragments_seen_next == expected_fragments_next);
    frame_active_next       = !done;
    drop_total_next         = drop_total + {31'd0, pdrop};
  end

  always_comb begin
    result = '0;
    result.status     = head_item.status;
    result.drop_count = drop_total;
    if (accepted) begin
      result.write_offset       = head_item.fragment_offset;
      result.write_length       = head_item.fragment_length;
      result.frame_started      = new_frame;
      result.partial_dropped    = pdrop;
      result.duplicate_fragment = dup;
      result.frame_complete     = done;
      result.complete_size      = done ? expected_bytes_next : 32'd0;
      result.drop_count         = drop_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active       <= 1'b0;
      cur_frame_number   <= '0;
      expected_bytes     <= '0;
      expected_fragments <= '0;
      fragments_seen     <= '0;
      seen_map           <= '0;
      drop_total         <= '0;
    end else if (pop && accepted) begin
      frame_active       <= frame_active_next;
      cur_frame_number   <= head_item.frame_number;
      expected_bytes     <= expected_bytes_next;
      expected_fragments <= expected_fragments_next;
      fragments_seen     <= fragments_seen_next;
      seen_map           <= seen_map_next;
      drop_total         <= drop_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result;
    end
  end

endmodule
